// ===== hdl/qfopm_pkg.sv =====
// shared types, coefficient table and microcode program for the plant model
package qfopm_pkg;

    // field widths
    localparam int CMD_W  = 16;
    localparam int OUT_W  = 24;
    localparam int COEF_W = 25;
    localparam int PROD_W = OUT_W + COEF_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int FRAC_SHIFT = 22;
    localparam int NUM_OUT = 6;
    localparam int NUM_CMD = 4;
    localparam int STEP_W  = 4;

    // operand select codes: stored outputs, then stored commands
    localparam logic [3:0] X_ROLL     = 4'd0;
    localparam logic [3:0] X_PITCH    = 4'd1;
    localparam logic [3:0] X_YAW      = 4'd2;
    localparam logic [3:0] X_VERT     = 4'd3;
    localparam logic [3:0] X_LAT      = 4'd4;
    localparam logic [3:0] X_FWD      = 4'd5;
    localparam logic [3:0] X_CMD_ROLL = 4'd6;
    localparam logic [3:0] X_CMD_PIT  = 4'd7;
    localparam logic [3:0] X_CMD_YAW  = 4'd8;
    localparam logic [3:0] X_CMD_THR  = 4'd9;

    // coefficient codes
    localparam logic [3:0] C_ROLL_A  = 4'd0;
    localparam logic [3:0] C_ROLL_B  = 4'd1;
    localparam logic [3:0] C_PITCH_A = 4'd2;
    localparam logic [3:0] C_PITCH_B = 4'd3;
    localparam logic [3:0] C_YAW_A   = 4'd4;
    localparam logic [3:0] C_YAW_B   = 4'd5;
    localparam logic [3:0] C_VERT_A  = 4'd6;
    localparam logic [3:0] C_VERT_B  = 4'd7;
    localparam logic [3:0] C_LAT_A   = 4'd8;
    localparam logic [3:0] C_LAT_B   = 4'd9;
    localparam logic [3:0] C_FWD_A   = 4'd10;
    localparam logic [3:0] C_FWD_B   = 4'd11;

    // output register slots
    localparam logic [2:0] W_ROLL  = 3'd0;
    localparam logic [2:0] W_PITCH = 3'd1;
    localparam logic [2:0] W_YAW   = 3'd2;
    localparam logic [2:0] W_VERT  = 3'd3;
    localparam logic [2:0] W_LAT   = 3'd4;
    localparam logic [2:0] W_FWD   = 3'd5;

    // one control word of the program
    typedef struct packed {
        logic       mul;     // load product register
        logic [3:0] x_sel;   // multiplier operand
        logic [3:0] c_sel;   // coefficient
        logic       ld;      // accumulator takes product
        logic       add;     // accumulator adds product
        logic       wr;      // rounded accumulator to an output slot
        logic [2:0] w_sel;
        logic       last;    // hold here until the result slot is free
    } t_uop;

    // control from the sequencer to the datapath
    typedef struct packed {
        logic start;   // capture the incoming commands
        logic commit;  // store commands, result leaves
        t_uop uop;
    } t_dp_ctl;

    // Q2.22 coefficients
    function automatic logic signed [COEF_W-1:0] coef_rom(input logic [3:0] idx);
        logic signed [COEF_W-1:0] c;
        case (idx)
            C_ROLL_A:  c = 25'sd4064563;
            C_ROLL_B:  c = 25'sd3892218;
            C_PITCH_A: c = 25'sd3938714;
            C_PITCH_B: c = 25'sd4651483;
            C_YAW_A:   c = 25'sd4022193;
            C_YAW_B:   c = 25'sd15782585;
            C_VERT_A:  c = 25'sd4064563;
            C_VERT_B:  c = 25'sd104656;
            C_LAT_A:   c = 25'sd4161491;
            C_LAT_B:   c = 25'sd8203;
            C_FWD_A:   c = 25'sd4165124;
            C_FWD_B:   c = -25'sd12021;
            default:   c = '0;
        endcase
        return c;
    endfunction

    function automatic t_uop mk(input logic mul, input logic [3:0] x_sel,
                                input logic [3:0] c_sel, input logic ld,
                                input logic add, input logic wr,
                                input logic [2:0] w_sel, input logic last);
        t_uop u;
        u.mul   = mul;
        u.x_sel = x_sel;
        u.c_sel = c_sel;
        u.ld    = ld;
        u.add   = add;
        u.wr    = wr;
        u.w_sel = w_sel;
        u.last  = last;
        return u;
    endfunction

    // program: multiply pipelined one step ahead of the accumulator
    function automatic t_uop ucode(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            4'd0:    u = mk(1'b1, X_ROLL,     C_ROLL_A,  1'b0, 1'b0, 1'b0, W_ROLL,  1'b0);
            4'd1:    u = mk(1'b1, X_CMD_ROLL, C_ROLL_B,  1'b1, 1'b0, 1'b0, W_ROLL,  1'b0);
            4'd2:    u = mk(1'b1, X_PITCH,    C_PITCH_A, 1'b0, 1'b1, 1'b0, W_ROLL,  1'b0);
            4'd3:    u = mk(1'b1, X_CMD_PIT,  C_PITCH_B, 1'b1, 1'b0, 1'b1, W_ROLL,  1'b0);
            4'd4:    u = mk(1'b1, X_YAW,      C_YAW_A,   1'b0, 1'b1, 1'b0, W_PITCH, 1'b0);
            4'd5:    u = mk(1'b1, X_CMD_YAW,  C_YAW_B,   1'b1, 1'b0, 1'b1, W_PITCH, 1'b0);
            4'd6:    u = mk(1'b1, X_VERT,     C_VERT_A,  1'b0, 1'b1, 1'b0, W_YAW,   1'b0);
            4'd7:    u = mk(1'b1, X_CMD_THR,  C_VERT_B,  1'b1, 1'b0, 1'b1, W_YAW,   1'b0);
            4'd8:    u = mk(1'b1, X_LAT,      C_LAT_A,   1'b0, 1'b1, 1'b0, W_VERT,  1'b0);
            4'd9:    u = mk(1'b1, X_ROLL,     C_LAT_B,   1'b1, 1'b0, 1'b1, W_VERT,  1'b0);
            4'd10:   u = mk(1'b1, X_FWD,      C_FWD_A,   1'b0, 1'b1, 1'b0, W_LAT,   1'b0);
            4'd11:   u = mk(1'b1, X_PITCH,    C_FWD_B,   1'b1, 1'b0, 1'b1, W_LAT,   1'b0);
            4'd12:   u = mk(1'b0, X_ROLL,     C_ROLL_A,  1'b0, 1'b1, 1'b0, W_FWD,   1'b0);
            4'd13:   u = mk(1'b0, X_ROLL,     C_ROLL_A,  1'b0, 1'b0, 1'b1, W_FWD,   1'b0);
            4'd14:   u = mk(1'b0, X_ROLL,     C_ROLL_A,  1'b0, 1'b0, 1'b0, W_ROLL,  1'b1);
            default: u = mk(1'b0, X_ROLL,     C_ROLL_A,  1'b0, 1'b0, 1'b0, W_ROLL,  1'b1);
        endcase
        return u;
    endfunction

endpackage

// ===== hdl/qfopm_datapath.sv =====
// multiply-accumulate datapath with filter state registers
module qfopm_datapath (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  qfopm_pkg::t_dp_ctl                            i_ctl,
    input  logic [qfopm_pkg::NUM_CMD-1:0][qfopm_pkg::CMD_W-1:0] i_cmds,
    output logic [qfopm_pkg::NUM_OUT-1:0][qfopm_pkg::OUT_W-1:0] o_outs
);
    import qfopm_pkg::*;

    logic [NUM_OUT-1:0][OUT_W-1:0] r_out;
    logic [NUM_CMD-1:0][CMD_W-1:0] r_cmd;
    logic [NUM_CMD-1:0][CMD_W-1:0] r_cmd_new;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;

    logic signed [OUT_W-1:0]       x_op;
    logic [1:0]                    cmd_idx;
    logic [3:0]                    cmd_off;
    logic signed [ACC_W-1:0]       prod_ext;
    logic signed [ACC_W-1:0]       rnd_sum;
    logic signed [ACC_W-FRAC_SHIFT-1:0] rnd_q;
    logic [OUT_W-1:0]              sat_val;

    // multiplier operand: stored output, or command scaled by 4
    always_comb begin
        cmd_off = i_ctl.uop.x_sel - X_CMD_ROLL;
        cmd_idx = cmd_off[1:0];
        case (i_ctl.uop.x_sel) inside
            [X_ROLL:X_FWD]: x_op = $signed(r_out[i_ctl.uop.x_sel[2:0]]);
            [X_CMD_ROLL:X_CMD_THR]: x_op = $signed({{(OUT_W-CMD_W-2){r_cmd[cmd_idx][CMD_W-1]}},
                                                    r_cmd[cmd_idx], 2'b00});
            default: x_op = '0;
        endcase
    end

    // round half up at bit 22, then clamp to 24 bits
    always_comb begin
        prod_ext = {r_prod[PROD_W-1], r_prod};
        rnd_sum  = r_acc + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
        rnd_q    = rnd_sum[ACC_W-1:FRAC_SHIFT];
        if (rnd_q > $signed((ACC_W-FRAC_SHIFT)'({1'b0, {(OUT_W-1){1'b1}}}))) begin
            sat_val = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (rnd_q < -$signed((ACC_W-FRAC_SHIFT)'({1'b1, {(OUT_W-1){1'b0}}}))) begin
            sat_val = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            sat_val = rnd_q[OUT_W-1:0];
        end
    end

    // product, accumulator and captured incoming commands
    always_ff @(posedge i_clk) begin
        if (i_ctl.uop.mul) begin
            r_prod <= x_op * coef_rom(i_ctl.uop.c_sel);
        end
        if (i_ctl.uop.ld) begin
            r_acc <= prod_ext;
        end else if (i_ctl.uop.add) begin
            r_acc <= r_acc + prod_ext;
        end
        if (i_ctl.start) begin
            r_cmd_new <= i_cmds;
        end
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
            r_cmd <= '0;
        end else begin
            if (i_ctl.uop.wr) begin
                r_out[i_ctl.uop.w_sel] <= sat_val;
            end
            if (i_ctl.commit) begin
                r_cmd <= r_cmd_new;
            end
        end
    end

    assign o_outs = r_out;

endmodule

// ===== hdl/quadrotor_first_order_plant_model_core.sv =====
// top level: microcoded sequencer, datapath and result register
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  command  | i_in_valid, o_in_ready, i_*_command       | in
//  state    | o_out_valid, i_out_ready, o_roll_angle .. | out
//
// words are taken only while idle: the program runs 15 control steps
// through a single 24x25 multiplier and one accumulator, and the next word
// is accepted once the sequencer is idle again. the result word sits in an
// output register, so the next word is accepted while it waits; only the
// final step stalls when that register is still full. reset clears the filter
// state and stored commands to zero.
module quadrotor_first_order_plant_model_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_roll_command,
    input  logic signed [15:0] i_pitch_command,
    input  logic signed [15:0] i_yaw_rate_command,
    input  logic signed [15:0] i_throttle_command,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [23:0] o_roll_angle,
    output logic signed [23:0] o_pitch_angle,
    output logic signed [23:0] o_yaw_rate,
    output logic signed [23:0] o_vertical_speed,
    output logic signed [23:0] o_lateral_speed,
    output logic signed [23:0] o_forward_speed
);
    import qfopm_pkg::*;

    logic                          r_busy;
    logic [STEP_W-1:0]             r_step;
    logic                          r_out_valid;
    logic [NUM_OUT-1:0][OUT_W-1:0] r_res;

    t_uop                          uop;
    t_dp_ctl                       ctl;
    logic                          accept;
    logic                          slot_free;
    logic [NUM_CMD-1:0][CMD_W-1:0] cmds;
    logic [NUM_OUT-1:0][OUT_W-1:0] outs;

    assign o_in_ready = !r_busy;
    assign accept     = i_in_valid && !r_busy;
    assign slot_free  = !r_out_valid || i_out_ready;
    assign cmds       = {i_throttle_command, i_yaw_rate_command,
                         i_pitch_command, i_roll_command};

    // control word fetch
    always_comb begin
        uop        = r_busy ? ucode(r_step) : '0;
        ctl.start  = accept;
        ctl.commit = r_busy && uop.last && slot_free;
        ctl.uop    = uop;
    end

    // step counter, holds on the final step until the result slot frees
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            if (uop.last) begin
                if (slot_free) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.commit) begin
            r_res <= outs;
        end
    end

    qfopm_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_cmds  (cmds),
        .o_outs  (outs)
    );

    assign o_out_valid      = r_out_valid;
    assign o_roll_angle     = $signed(r_res[W_ROLL]);
    assign o_pitch_angle    = $signed(r_res[W_PITCH]);
    assign o_yaw_rate       = $signed(r_res[W_YAW]);
    assign o_vertical_speed = $signed(r_res[W_VERT]);
    assign o_lateral_speed  = $signed(r_res[W_LAT]);
    assign o_forward_speed  = $signed(r_res[W_FWD]);

endmodule
